// File: design/tcf_pkg.sv
// shared types, codes and constants for the tilt complementary filter
package tcf_pkg;

  typedef struct packed {
    logic        [1:0]  mode;
    logic        [1:0]  action;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
  } tcf_in_t;

  typedef struct packed {
    logic signed [31:0] pitch_out;
    logic signed [31:0] roll_out;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic               moving;
    logic               scrolling;
  } tcf_out_t;

  localparam logic [1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [1:0] MODE_PRESS   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] ACT_MOVE   = 2'd0;
  localparam logic [1:0] ACT_SCROLL = 2'd1;

  localparam logic [1:0] REG_WEIGHT  = 2'd0;
  localparam logic [1:0] REG_MULT    = 2'd1;
  localparam logic [1:0] REG_DIVISOR = 2'd2;

  localparam logic [15:0] WEIGHT_RST = 16'd64225;

  typedef enum logic [3:0] {
    S_IDLE, S_SQA, S_SQB, S_SQRT_GO, S_SQRT_WT, S_CORD_GO, S_CORD_WT,
    S_BL1, S_BL2, S_DMUL, S_DIV_GO, S_DIV_WT, S_OUT
  } tcf_state_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_step(input logic [4:0] i);
    logic signed [33:0] v;
    case (i)
      5'd0:    v = 34'sd843314857;
      5'd1:    v = 34'sd497837829;
      5'd2:    v = 34'sd263043837;
      5'd3:    v = 34'sd133525159;
      5'd4:    v = 34'sd67021687;
      5'd5:    v = 34'sd33543516;
      5'd6:    v = 34'sd16775851;
      5'd7:    v = 34'sd8388437;
      5'd8:    v = 34'sd4194283;
      5'd9:    v = 34'sd2097149;
      default: v = (34'sd1 <<< 30) >>> i;
    endcase
    return v;
  endfunction

endpackage

// File: design/tcf_isqrt.sv
// iterative integer square root of a value scaled by 2^16, two radicand bits per cycle
module tcf_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] val,
  output logic [23:0] root,
  output logic        done
);
  logic [47:0] rad_r;
  logic [26:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r;
  logic [26:0] rem_sh, trial;
  logic        fit;

  assign rem_sh = {rem_r[24:0], rad_r[47:46]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fit    = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'd0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rad_r  <= {val, 16'd0};
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= 5'd23;
    end else if (run_r) begin
      rad_r  <= {rad_r[45:0], 2'b00};
      rem_r  <= fit ? rem_sh - trial : rem_sh;
      root_r <= {root_r[22:0], fit};
      cnt_r  <= cnt_r - 5'd1;
    end
  end

  assign root = root_r;
  assign done = done_r;
endmodule

// File: design/tcf_cordic.sv
// iterative cordic vectoring unit giving atan(y/x) in q15.16
module tcf_cordic #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic [23:0]        x0,
  input  logic signed [24:0] y0,
  output logic signed [31:0] angle,
  output logic               done
);
  import tcf_pkg::*;

  localparam logic [4:0] LAST = 5'(STEPS - 1);

  logic signed [27:0] x_r, y_r;
  logic signed [33:0] z_r, z_rnd;
  logic [4:0]         i_r;
  logic               run_r, done_r, zero_r;
  logic signed [27:0] dx, dy;
  logic signed [33:0] za;

  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign za = atan_step(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && i_r == LAST) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r    <= 28'(signed'({1'b0, x0}));
      y_r    <= 28'(y0);
      z_r    <= '0;
      i_r    <= '0;
      zero_r <= (x0 == '0) && (y0 == '0);
    end else if (run_r) begin
      if (y_r > 0) begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + za;
      end else begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - za;
      end
      i_r <= i_r + 5'd1;
    end
  end

  assign z_rnd = (z_r + 34'sd8192) >>> 14;
  assign angle = zero_r ? '0 : z_rnd[31:0];
  assign done  = done_r;
endmodule

// File: design/tcf_div.sv
// restoring divider, one quotient bit per cycle
module tcf_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [30:0] dividend,
  input  logic [15:0] divisor,
  output logic [30:0] quot,
  output logic        done
);
  logic [30:0] q_r;
  logic [15:0] rem_r, d_r;
  logic [4:0]  cnt_r;
  logic        run_r, done_r;
  logic [16:0] rem_sh;
  logic        fit;

  assign rem_sh = {rem_r, q_r[30]};
  assign fit    = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'd0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= (divisor == '0) ? 16'd1 : divisor;
      cnt_r <= 5'd30;
    end else if (run_r) begin
      rem_r <= fit ? 16'(rem_sh - {1'b0, d_r}) : rem_sh[15:0];
      q_r   <= {q_r[29:0], fit};
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign quot = q_r;
  assign done = done_r;
endmodule

// File: design/imu_tilt_complementary_filter_core.sv
// top level of the imu tilt complementary filter with sequencer and register port
// Pitch and roll are worked one after the other. Each angle passes through two
// squaring states, a 24-step square root, CORDIC_STEPS cordic steps (16 by default),
// two blend multiply states, one delta multiply and a 31-step divide; each iterative
// unit has a start state before it and a wait state that ends on its done pulse.
// The output state follows the roll pass, and the input is ready again once the
// sequencer is back in idle. Press and release transactions are taken in idle and
// start no work. The input stalls while a sample is in work. A finished result
// sits in the output register, and a new transaction may be taken meanwhile. A
// sample that finishes while the previous result is still stalled waits in its
// output state.
module imu_tilt_complementary_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tcf_pkg::tcf_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tcf_pkg::tcf_out_t out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tcf_pkg::*;

  tcf_state_t state_r, state_nxt;

  logic [15:0]        weight_r, divisor_r;
  logic signed [15:0] mult_r;
  logic               move_r, scroll_r, ph_r;
  tcf_in_t            smp_r;
  logic [31:0]        s_r;
  logic signed [50:0] prod1_r;
  logic signed [47:0] prodd_r;
  logic signed [31:0] pitch_r, roll_r;
  logic signed [15:0] dx_r, dy_r;
  logic               out_valid_r;
  tcf_out_t           out_r;

  logic in_acc, cfg_wr, sqrt_go, cord_go, div_go;
  logic sqrt_done, cord_done, div_done;
  logic [23:0]        root;
  logic signed [31:0] acc_ang;
  logic [30:0]        quot;

  logic signed [16:0] num;
  logic signed [15:0] opa, opb, rate;
  logic signed [31:0] last, cur;
  logic signed [33:0] p;
  logic signed [17:0] wc;
  logic signed [51:0] sum;
  logic signed [35:0] bl;
  logic signed [31:0] bl_sat;
  logic               neg;
  logic [47:0]        pmag;
  logic signed [15:0] dsat;

  assign pready   = 1'b1;
  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_WEIGHT:  prdata = {16'd0, weight_r};
      REG_MULT:    prdata = 32'(mult_r);
      REG_DIVISOR: prdata = {16'd0, divisor_r};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r  <= WEIGHT_RST;
      mult_r    <= 16'sd1;
      divisor_r <= 16'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WEIGHT:  weight_r  <= pwdata[15:0];
        REG_MULT:    mult_r    <= pwdata[15:0];
        REG_DIVISOR: divisor_r <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  // operand selection for the angle in work
  always_comb begin
    if (!ph_r) begin
      num  = -17'(smp_r.accel_x);
      opa  = smp_r.accel_y;
      last = pitch_r;
      rate = smp_r.gyro_y;
    end else begin
      num  = 17'(smp_r.accel_y);
      opa  = smp_r.accel_x;
      last = roll_r;
      rate = smp_r.gyro_x;
    end
    opb = smp_r.accel_z;
    cur = ph_r ? roll_r : pitch_r;
  end

  assign p    = 34'(last) + (34'(rate) <<< 4);
  assign wc   = 18'sd65536 - 18'(signed'({1'b0, weight_r}));
  assign sum  = 52'(prod1_r) + 52'(wc * acc_ang) + 52'sd32768;
  assign bl   = 36'(sum >>> 16);
  assign bl_sat = (bl > 36'sd2147483647) ? 32'sh7fffffff :
                  (bl < -36'sd2147483648) ? 32'sh80000000 : bl[31:0];

  assign neg  = prodd_r < 0;
  assign pmag = neg ? 48'(-prodd_r) : 48'(prodd_r);
  always_comb begin
    if (neg) begin
      dsat = (quot > 31'd32768) ? -16'sd32768 : -16'(quot[15:0]);
    end else begin
      dsat = (quot > 31'd32767) ? 16'sd32767 : 16'(quot[15:0]);
    end
  end

  tcf_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .go(sqrt_go), .val(s_r), .root(root), .done(sqrt_done)
  );

  tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .go(cord_go), .x0(root), .y0(25'(num) <<< 8),
    .angle(acc_ang), .done(cord_done)
  );

  tcf_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(pmag[46:16]),
    .divisor(divisor_r), .quot(quot), .done(div_done)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_data.mode == MODE_SAMPLE && (move_r || scroll_r)) state_nxt = S_SQA;
      end
      S_SQA:     state_nxt = S_SQB;
      S_SQB:     state_nxt = S_SQRT_GO;
      S_SQRT_GO: state_nxt = S_SQRT_WT;
      S_SQRT_WT: if (sqrt_done) state_nxt = S_CORD_GO;
      S_CORD_GO: state_nxt = S_CORD_WT;
      S_CORD_WT: if (cord_done) state_nxt = S_BL1;
      S_BL1:     state_nxt = S_BL2;
      S_BL2:     state_nxt = S_DMUL;
      S_DMUL:    state_nxt = S_DIV_GO;
      S_DIV_GO:  state_nxt = S_DIV_WT;
      S_DIV_WT:  if (div_done) state_nxt = ph_r ? S_OUT : S_SQA;
      S_OUT:     if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    sqrt_go = state_r == S_SQRT_GO;
    cord_go = state_r == S_CORD_GO;
    div_go  = state_r == S_DIV_GO;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      move_r      <= 1'b0;
      scroll_r    <= 1'b0;
      pitch_r     <= '0;
      roll_r      <= '0;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && (in_data.mode == MODE_PRESS || in_data.mode == MODE_RELEASE)) begin
        if (in_data.action == ACT_MOVE) move_r <= in_data.mode == MODE_PRESS;
        if (in_data.action == ACT_SCROLL) scroll_r <= in_data.mode == MODE_PRESS;
      end
      if (state_r == S_IDLE) ph_r <= 1'b0;
      if (state_r == S_DIV_WT && div_done) ph_r <= 1'b1;
      if (state_r == S_BL2) begin
        if (ph_r) roll_r <= bl_sat;
        else pitch_r <= bl_sat;
      end
      if (state_r == S_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) smp_r <= in_data;
    case (state_r)
      S_SQA:   s_r <= 32'(opa * opa);
      S_SQB:   s_r <= s_r + 32'(opb * opb);
      S_BL1:   prod1_r <= 51'(signed'({1'b0, weight_r})) * 51'(p);
      S_DMUL:  prodd_r <= 48'(cur) * 48'(mult_r);
      S_DIV_WT: begin
        if (div_done) begin
          if (ph_r) dy_r <= dsat;
          else dx_r <= dsat;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_r.pitch_out <= pitch_r;
          out_r.roll_out  <= roll_r;
          out_r.delta_x   <= dx_r;
          out_r.delta_y   <= dy_r;
          out_r.moving    <= move_r;
          out_r.scrolling <= scroll_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT)) else $error("result without sequence");

  a_out_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.moving || out_r.scrolling)) else $error("result while disabled");

  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.mode == MODE_SAMPLE && !move_r && !scroll_r) |=> state_r == S_IDLE)
    else $error("disabled sample started work");

  a_div_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV_WT && div_done && !ph_r) |=> (state_r == S_SQA && ph_r))
    else $error("roll pass not started");
endmodule

// File: test/imu_tilt_complementary_filter_core_test.sv
// testbench for the imu tilt complementary filter: directed table, then random sensor and event traffic
`timescale 1ns / 1ps
module imu_tilt_complementary_filter_core_test;
  import tcf_pkg::*;

  localparam logic [1:0] MODE_BAD   = 2'd3;
  localparam logic [1:0] ACT_BAD_LO = 2'd2;
  localparam logic [1:0] ACT_BAD_HI = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  tcf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tcf_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  imu_tilt_complementary_filter_core uut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  typedef struct {
    tcf_in_t item;
    bit      fixed;
    tcf_out_t res;
  } row_t;

  logic [15:0] weight_q;
  logic signed [15:0] mult_q;
  logic [15:0] div_q;
  logic signed [31:0] pitch_q, roll_q;
  bit move_q, scroll_q;

  tcf_out_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int samples_sent = 0;
  int events_sent = 0;
  bit stall_enable = 1'b1;

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint tilt_angle(longint n, longint a, longint b);
    longint x, y, z, dx, dy, st;
    x = int_sqrt(longint'(a * a + b * b) << 16);
    y = n * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      st = longint'(atan_step(i[4:0]));
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + st;
      end else begin
        x = x - dx; y = y + dy; z = z - st;
      end
    end
    return shr_floor(z + 8192, 14);
  endfunction

  function automatic logic signed [31:0] fuse(logic signed [31:0] last, longint rate, longint acc);
    longint w, p, v;
    w = longint'(weight_q);
    p = longint'(last) + rate * 16;
    v = shr_floor(w * p + (65536 - w) * acc + 32768, 16);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] scaled_delta(logic signed [31:0] ang);
    longint d, v;
    d = (div_q == 0) ? 1 : longint'(div_q);
    v = (longint'(ang) * longint'(mult_q)) / (d * 65536);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic bit predict_filter(tcf_in_t it, output tcf_out_t r);
    r = '0;
    if (it.mode == MODE_PRESS || it.mode == MODE_RELEASE) begin
      if (it.action == ACT_MOVE) move_q = (it.mode == MODE_PRESS);
      else if (it.action == ACT_SCROLL) scroll_q = (it.mode == MODE_PRESS);
      return 0;
    end
    if (it.mode != MODE_SAMPLE || (!move_q && !scroll_q)) return 0;
    pitch_q = fuse(pitch_q, longint'(it.gyro_y),
                   tilt_angle(-longint'(it.accel_x), longint'(it.accel_y), longint'(it.accel_z)));
    roll_q = fuse(roll_q, longint'(it.gyro_x),
                  tilt_angle(longint'(it.accel_y), longint'(it.accel_x), longint'(it.accel_z)));
    r.pitch_out = pitch_q;
    r.roll_out = roll_q;
    r.delta_x = scaled_delta(pitch_q);
    r.delta_y = scaled_delta(roll_q);
    r.moving = move_q;
    r.scrolling = scroll_q;
    return 1;
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WEIGHT:  weight_q = val;
      REG_MULT:    mult_q = val;
      default:     div_q = val;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic send_item(tcf_in_t it, bit fixed, tcf_out_t fixed_res, bit gaps);
    tcf_out_t r;
    int gap;
    gap = gaps ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    if (predict_filter(it, r)) begin
      if (fixed) r = fixed_res;
      pending_results.push_back(r);
    end
    if (it.mode == MODE_SAMPLE) samples_sent++;
    else events_sent++;
  endtask

  function automatic tcf_in_t mk(logic [1:0] m, logic [1:0] a, int ax, int ay, int az,
                                 int gx, int gy);
    tcf_in_t t;
    t.mode = m; t.action = a;
    t.accel_x = ax[15:0]; t.accel_y = ay[15:0]; t.accel_z = az[15:0];
    t.gyro_x = gx[15:0]; t.gyro_y = gy[15:0];
    return t;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          if (out_data !== pending_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", pending_results[0], out_data);
          end
          void'(pending_results.pop_front());
        end
      end
    end
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall && stall_enable) begin
        hold = $urandom_range(0, 16);
        out_stall <= (hold > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #400ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    row_t rows[$];
    tcf_in_t it;
    tcf_out_t zero_res;
    int pick;
    logic [95:0] rnd;
    logic [15:0] wts[4];
    logic [15:0] mls[4];
    logic [15:0] dvs[4];
    zero_res = '0;
    weight_q = WEIGHT_RST; mult_q = 16'sd1; div_q = 16'd1;
    pitch_q = 0; roll_q = 0; move_q = 0; scroll_q = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // disabled sample gives nothing, then enable and zero over zero
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 100, 200, 300, 5, 5), 0, zero_res});
    rows.push_back('{mk(MODE_PRESS, ACT_MOVE, 0, 0, 0, 0, 0), 0, zero_res});
    zero_res.moving = 1'b1;
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 0, 0, 0, 0, 0), 1, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 32767, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, -32768, -32768, -32768, -32768, -32768), 0,
                     zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 32767, 32767, 32767, 32767, 32767), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 0, 0, 16384, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 0, -32768, 0, 100, -100), 0, zero_res});
    rows.push_back('{mk(MODE_PRESS, ACT_SCROLL, 0, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_PRESS, ACT_BAD_LO, 0, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_RELEASE, ACT_BAD_HI, 0, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 1000, -2000, 3000, -50, 60), 0, zero_res});
    rows.push_back('{mk(MODE_RELEASE, ACT_MOVE, 0, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, -1, 1, -1, 1, -1), 0, zero_res});
    rows.push_back('{mk(MODE_BAD, 2'd0, 5, 5, 5, 5, 5), 0, zero_res});
    rows.push_back('{mk(MODE_RELEASE, ACT_SCROLL, 0, 0, 0, 0, 0), 0, zero_res});
    rows.push_back('{mk(MODE_SAMPLE, 2'd0, 9, 9, 9, 9, 9), 0, zero_res});
    foreach (rows[i]) send_item(rows[i].item, rows[i].fixed, rows[i].res, 1'b0);
    drain_results();

    wts = '{16'd0, 16'd65535, WEIGHT_RST, 16'd32768};
    mls = '{16'h7fff, 16'h8000, 16'd1, 16'hfc18};
    dvs = '{16'd0, 16'd65535, 16'd1, 16'd3};
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        reg_write(REG_WEIGHT, (ph < 5) ? wts[ph - 1] : 16'($urandom()));
        reg_write(REG_MULT, (ph < 5) ? mls[ph - 1] : 16'($urandom()));
        reg_write(REG_DIVISOR, (ph < 5) ? dvs[ph - 1] : 16'($urandom()));
      end
      stall_enable = (ph != 2);
      for (int n = 0; n < 225; n++) begin
        pick = $urandom_range(0, 99);
        rnd = {$urandom(), $urandom(), $urandom()};
        it = rnd[83:0];
        if (pick < 8) begin
          it.mode = ($urandom_range(0, 3) == 0) ? MODE_RELEASE : MODE_PRESS;
        end else if (pick < 10) begin
          it.mode = MODE_BAD;
        end else begin
          it.mode = MODE_SAMPLE;
          if ($urandom_range(0, 3) == 0) begin
            it.accel_x = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            it.accel_y = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            it.accel_z = $signed(16'($urandom_range(0, 64))) - 16'sd32;
          end
        end
        if (!move_q && !scroll_q && pick < 20) begin
          it.mode = MODE_PRESS;
          it.action = 2'($urandom_range(0, 1));
        end
        send_item(it, 1'b0, zero_res, (ph != 3));
        if (n == 100) drain_results();
      end
      drain_results();
    end

    $display("sent %0d samples and %0d events over six register settings", samples_sent,
             events_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/tcf_pkg.sv
design/tcf_isqrt.sv
design/tcf_cordic.sv
design/tcf_div.sv
design/imu_tilt_complementary_filter_core.sv
test/imu_tilt_complementary_filter_core_test.sv
